/* hw/rtl/hrfl_pkg.sv */
// ============================================================================
// HTTP request head field locator: shared types and constants
// Result layout, field codes and the byte constants used by the scanner.
// ============================================================================
package hrfl_pkg;

    // Field codes carried by every result.
    typedef enum logic [2:0] {
        KIND_METHOD  = 3'd0,
        KIND_URL     = 3'd1,
        KIND_VERSION = 3'd2,
        KIND_HOST    = 3'd3,
        KIND_ERROR   = 3'd4
    } field_kind_t;

    // One located field.
    typedef struct packed {
        field_kind_t kind;
        logic [11:0] offset;
        logic [12:0] length;
        logic        closes_head;
    } result_t;

    // A result together with its write strobe into the result queue.
    typedef struct packed {
        logic    valid;
        result_t data;
    } result_slot_t;

    // Delimiter and keyword bytes.
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_H     = 8'h48;

    // The keyword is four bytes long; the host value starts six bytes after its 'H'.
    localparam int HOST_WORD_LEN     = 4;
    localparam int HOST_VALUE_OFFSET = 6;
    // Bytes skipped between the final keyword byte and the host value.
    localparam int HOST_SKIP_BYTES   = HOST_VALUE_OFFSET - HOST_WORD_LEN;

    // Result queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Byte of the keyword "Host" at a given match index.
    function automatic logic [7:0] host_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h48;
            2'd1:    c = 8'h6F;
            2'd2:    c = 8'h73;
            2'd3:    c = 8'h74;
            default: c = 8'h48;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/http_request_head_field_locator.sv */
// ============================================================================
// HTTP request head field locator
// Scans an HTTP request head byte by byte and reports its field positions.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready): one byte of the head per transaction,
//   with end_of_data set on its final byte.
//   Output channel (out_valid/out_ready): one located field per transaction:
//   method, URL, version and host value, each with offset and length, or an
//   error when the data ends early or the head exceeds MAX_HEAD_BYTES.
//   final_result marks the host or error result that completes a head.
//   Throughput is one byte per cycle while in_ready is high. A result is
//   queued as the byte that closed its field is taken and presented once
//   earlier results have left; a byte yields at most two results. Results
//   wait in a four-entry queue, and in_ready falls while fewer than two
//   entries are free, so a stalled receiver holds input back with nothing lost.
//   After the final result the remaining bytes of the head are dropped until
//   end_of_data, and the scanner then rearms for the next head.
//   Reset empties the queue and returns the scanner to the start of a head.
// ============================================================================
module http_request_head_field_locator
    import hrfl_pkg::*;
#(
    parameter int MAX_HEAD_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_value,
    input  logic        end_of_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  field_kind,
    output logic [11:0] field_offset,
    output logic [12:0] field_length,
    output logic        final_result
);

    result_slot_t res0;
    result_slot_t res1;
    result_t      head;
    logic         has_room;
    logic         take;

    assign in_ready = has_room;
    assign take     = in_valid && has_room;

    hrfl_parser #(
        .MAX_HEAD_BYTES (MAX_HEAD_BYTES)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .byte_value  (byte_value),
        .end_of_data (end_of_data),
        .res0        (res0),
        .res1        (res1)
    );

    hrfl_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .res0      (res0),
        .res1      (res1),
        .has_room  (has_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    // Result fields to the output ports.
    assign field_kind   = head.kind;
    assign field_offset = head.offset;
    assign field_length = head.length;
    assign final_result = head.closes_head;

endmodule

/* hw/rtl/hrfl_parser.sv */
// ============================================================================
// HTTP request head field locator: byte scanner
// Holds the parse state and turns each accepted byte into up to two results.
// ============================================================================
module hrfl_parser
    import hrfl_pkg::*;
#(
    parameter int MAX_HEAD_BYTES = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         take,
    input  logic [7:0]   byte_value,
    input  logic         end_of_data,
    output result_slot_t res0,
    output result_slot_t res1
);

    localparam int PW = $clog2(MAX_HEAD_BYTES + 1);
    localparam logic [PW-1:0] MAX_POS = PW'(MAX_HEAD_BYTES);

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_URL     = 3'd1,
        PH_VERSION = 3'd2,
        PH_SEARCH  = 3'd3,
        PH_SKIP    = 3'd4,
        PH_HOST    = 3'd5,
        PH_DRAIN   = 3'd6
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [12:0]   fs_reg, fs_next;
    logic [2:0]    km_reg, km_next;
    logic [1:0]    skip_reg, skip_next;
    logic          cr_reg, cr_next;

    logic [PW+12:0] pos_wide;
    logic [12:0]    p13;
    logic [1:0]     skip_dec;
    logic           lf_close;
    logic           fin;
    logic           first_valid;
    logic           err_valid;
    result_t        first;
    result_t        err;

    // Position reduced to the 13 bits that offsets and lengths are taken from.
    assign pos_wide = {13'd0, pos_reg};
    assign p13      = pos_wide[12:0];
    assign lf_close = (byte_value == CHAR_LF) && cr_reg;
    assign skip_dec = (skip_reg != 2'd0) ? skip_reg - 2'd1 : skip_reg;

    // Next state and results for the byte at the input.
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        fs_next     = fs_reg;
        km_next     = km_reg;
        skip_next   = skip_reg;
        cr_next     = cr_reg;
        fin         = 1'b0;
        first_valid = 1'b0;
        err_valid   = 1'b0;
        first       = '0;
        err         = '{kind: KIND_ERROR, offset: 12'd0, length: 13'd0, closes_head: 1'b1};

        if (phase_reg != PH_DRAIN)
        begin
            if (pos_reg >= MAX_POS)
            begin
                // Head too long: the byte is not parsed.
                first_valid = 1'b1;
                first       = err;
                fin         = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_METHOD, PH_URL:
                    begin
                        if (byte_value == CHAR_SPACE)
                        begin
                            first_valid        = 1'b1;
                            first.kind         = (phase_reg == PH_METHOD) ? KIND_METHOD : KIND_URL;
                            first.offset       = fs_reg[11:0];
                            first.length       = p13 - fs_reg;
                            first.closes_head  = 1'b0;
                            fs_next            = p13 + 13'd1;
                            cr_next            = 1'b0;
                            phase_next         = (phase_reg == PH_METHOD) ? PH_URL : PH_VERSION;
                        end
                    end
                    PH_VERSION:
                    begin
                        cr_next = (byte_value == CHAR_CR);
                        if (lf_close)
                        begin
                            first_valid       = 1'b1;
                            first.kind        = KIND_VERSION;
                            first.offset      = fs_reg[11:0];
                            first.length      = p13 - 13'd1 - fs_reg;
                            first.closes_head = 1'b0;
                            km_next           = 3'd0;
                            phase_next        = PH_SEARCH;
                        end
                    end
                    PH_SEARCH:
                    begin
                        if ((km_reg < 3'(HOST_WORD_LEN)) && (byte_value == host_char(km_reg[1:0])))
                        begin
                            km_next = km_reg + 3'd1;
                            if (km_reg == 3'(HOST_WORD_LEN - 1))
                            begin
                                fs_next    = p13 + 13'(HOST_SKIP_BYTES + 1);
                                skip_next  = 2'(HOST_SKIP_BYTES);
                                phase_next = PH_SKIP;
                            end
                        end
                        else
                        begin
                            km_next = (byte_value == CHAR_H) ? 3'd1 : 3'd0;
                        end
                    end
                    PH_SKIP:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 2'd0)
                        begin
                            cr_next    = 1'b0;
                            phase_next = PH_HOST;
                        end
                    end
                    PH_HOST:
                    begin
                        cr_next = (byte_value == CHAR_CR);
                        if (lf_close)
                        begin
                            first_valid       = 1'b1;
                            first.kind        = KIND_HOST;
                            first.offset      = fs_reg[11:0];
                            first.length      = p13 - 13'd1 - fs_reg;
                            first.closes_head = 1'b1;
                            fin               = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                pos_next = pos_reg + PW'(1);
            end

            // Data ended before the head was complete.
            err_valid = !fin && end_of_data;
            if (!end_of_data && fin)
            begin
                phase_next = PH_DRAIN;
            end
        end

        // The final byte of a head rearms the scanner in every phase.
        if (end_of_data)
        begin
            phase_next = PH_METHOD;
            pos_next   = '0;
            fs_next    = '0;
            km_next    = '0;
            skip_next  = '0;
            cr_next    = 1'b0;
        end
    end

    // Pack the results so that the first used slot is always slot zero.
    always_comb
    begin
        res0.valid = take && (first_valid || err_valid);
        res0.data  = first_valid ? first : err;
        res1.valid = take && first_valid && err_valid;
        res1.data  = err;
    end

    // Parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_METHOD;
            pos_reg   <= '0;
            fs_reg    <= '0;
            km_reg    <= '0;
            skip_reg  <= '0;
            cr_reg    <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            fs_reg    <= fs_next;
            km_reg    <= km_next;
            skip_reg  <= skip_next;
            cr_reg    <= cr_next;
        end
    end

    // The position never runs past the size limit.
    assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= MAX_POS)
        else $error("byte position beyond head size limit");

    // The skip phase always has bytes left to skip.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |-> (skip_reg != 2'd0))
        else $error("skip phase entered with nothing to skip");

    // A complete keyword match always leaves the search phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SEARCH) |-> (km_reg < 3'(HOST_WORD_LEN)))
        else $error("keyword match count overran in search phase");

    // A second result in one step is only ever an early-end error.
    assert property (@(posedge clk) disable iff (!rst_n)
        res1.valid |-> (res0.valid && end_of_data && (res1.data.kind == KIND_ERROR)))
        else $error("second result without early end of data");

endmodule

/* hw/rtl/hrfl_result_queue.sv */
// ============================================================================
// HTTP request head field locator: result queue
// Small register queue that takes up to two results a cycle and issues one.
// ============================================================================
module hrfl_result_queue
    import hrfl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  result_slot_t res0,
    input  result_slot_t res1,
    output logic         has_room,
    output logic         out_valid,
    input  logic         out_ready,
    output result_t      head
);

    result_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [QPTR_W-1:0]   wr_ptr_plus1;
    logic [1:0]          n_push;
    logic                pop;

    // Room for two results is needed before a byte may be taken.
    assign has_room  = count_reg <= QCNT_W'(QUEUE_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and occupancy update.
    always_comb
    begin
        n_push       = {1'b0, res0.valid} + {1'b0, res1.valid};
        wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);
        wr_ptr_next  = wr_ptr_reg + QPTR_W'(n_push);
        rd_ptr_next  = rd_ptr_reg + QPTR_W'(pop);
        count_next   = count_reg + QCNT_W'(n_push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (res0.valid)
        begin
            mem_reg[wr_ptr_reg] <= res0.data;
        end
        if (res1.valid)
        begin
            mem_reg[wr_ptr_plus1] <= res1.data;
        end
    end

    // Occupancy never exceeds the storage.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // Results are only written when there was room for them.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res0.valid || res1.valid) |-> has_room)
        else $error("result written into a full queue");

    // The second slot is never used alone.
    assert property (@(posedge clk) disable iff (!rst_n) res1.valid |-> res0.valid)
        else $error("second result slot used without the first");

endmodule

/* dv/http_request_head_field_locator_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// HTTP request head field locator testbench
// Streams request heads into the scanner one byte per transaction, predicts
// the located fields with an independent scanner model and checks every
// result transaction against it, with random idling on both channels.
// ============================================================================
module http_request_head_field_locator_tb;
    import hrfl_pkg::*;

    localparam int  CLK_PERIOD     = 12;
    localparam int  HEAD_LIMIT     = 4096;
    localparam int  SHORT_ITEMS    = 900;
    localparam int  HOLD_CYCLES    = 300;
    localparam int  DRAIN_CYCLES   = 16;
    localparam int  TIMEOUT_CYCLES = 2_500_000;
    localparam logic [31:0] HOST_WORD = "Host";

    // Scanner phases of the prediction.
    typedef enum logic [2:0] {
        SCAN_METHOD,
        SCAN_URL,
        SCAN_VERSION,
        SCAN_HOST_WORD,
        SCAN_SKIP,
        SCAN_HOST_VALUE,
        SCAN_DRAIN
    } scan_phase_t;

    // One byte of a head as it is offered on the input channel.
    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } head_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  byte_value = 8'h00;
    logic        end_of_data = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  field_kind;
    logic [11:0] field_offset;
    logic [12:0] field_length;
    logic        final_result;

    head_byte_t  pending_bytes[$];
    logic [7:0]  head_buf[$];
    result_t     field_queue[$];

    int          total_bytes = 0;
    int          bytes_taken = 0;
    int          fields_seen = 0;
    int          mismatch_count = 0;
    int          send_wait = 0;
    int          recv_wait = 0;
    logic        hold_off = 1'b0;

    // Prediction state.
    scan_phase_t scan_phase = SCAN_METHOD;
    logic [31:0] head_pos = '0;
    logic [31:0] open_start = '0;
    int          word_matched = 0;
    int          skip_left = 0;
    logic        cr_pending = 1'b0;

    http_request_head_field_locator #(
        .MAX_HEAD_BYTES(HEAD_LIMIT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_value  (byte_value),
        .end_of_data (end_of_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .field_kind  (field_kind),
        .field_offset(field_offset),
        .field_length(field_length),
        .final_result(final_result)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Idle cycles before the next transaction; every third stretch of one
    // hundred transactions runs back to back.
    function automatic int pick_gap(input int n);
        if ((n / 100) % 3 == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // ------------------------------------------------------------------
    // Field prediction
    // ------------------------------------------------------------------
    function automatic void rearm_scanner();
        scan_phase   = SCAN_METHOD;
        head_pos     = '0;
        open_start   = '0;
        word_matched = 0;
        skip_left    = 0;
        cr_pending   = 1'b0;
    endfunction

    function automatic void log_field(input field_kind_t kind, input logic [31:0] off,
                                      input logic [31:0] len, input logic fin);
        result_t r;
        r.kind        = kind;
        r.offset      = off[11:0];
        r.length      = len[12:0];
        r.closes_head = fin;
        field_queue.push_back(r);
    endfunction

    function automatic void predict_fields(input logic [7:0] b, input logic eod);
        logic [31:0] p;
        logic        closed;
        logic        crlf;
        p      = head_pos;
        closed = 1'b0;
        crlf   = 1'b0;

        // After the final result everything up to the end of data is dropped.
        if (scan_phase == SCAN_DRAIN)
        begin
            if (eod)
                rearm_scanner();
            return;
        end

        if (p >= HEAD_LIMIT)
        begin
            log_field(KIND_ERROR, 32'd0, 32'd0, 1'b1);
            closed = 1'b1;
        end
        else
        begin
            case (scan_phase)
                SCAN_METHOD, SCAN_URL:
                begin
                    if (b == CHAR_SPACE)
                    begin
                        log_field(scan_phase == SCAN_METHOD ? KIND_METHOD : KIND_URL,
                                  open_start, p - open_start, 1'b0);
                        open_start = p + 1;
                        cr_pending = 1'b0;
                        scan_phase = (scan_phase == SCAN_METHOD) ? SCAN_URL : SCAN_VERSION;
                    end
                end
                SCAN_VERSION:
                begin
                    crlf       = (b == CHAR_LF) && cr_pending;
                    cr_pending = (b == CHAR_CR);
                    if (crlf)
                    begin
                        log_field(KIND_VERSION, open_start, p - 1 - open_start, 1'b0);
                        word_matched = 0;
                        scan_phase   = SCAN_HOST_WORD;
                    end
                end
                SCAN_HOST_WORD:
                begin
                    if (word_matched < 4 && b == HOST_WORD[31 - 8 * word_matched -: 8])
                    begin
                        word_matched++;
                        if (word_matched == 4)
                        begin
                            open_start = p + 3;
                            skip_left  = 2;
                            scan_phase = SCAN_SKIP;
                        end
                    end
                    else
                        word_matched = (b == CHAR_H) ? 1 : 0;
                end
                SCAN_SKIP:
                begin
                    if (skip_left > 0)
                        skip_left--;
                    if (skip_left == 0)
                    begin
                        cr_pending = 1'b0;
                        scan_phase = SCAN_HOST_VALUE;
                    end
                end
                SCAN_HOST_VALUE:
                begin
                    crlf       = (b == CHAR_LF) && cr_pending;
                    cr_pending = (b == CHAR_CR);
                    if (crlf)
                    begin
                        log_field(KIND_HOST, open_start, p - 1 - open_start, 1'b1);
                        closed = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            head_pos = p + 1;
        end

        // Data ending before the host value closes is an error.
        if (!closed && eod)
            log_field(KIND_ERROR, 32'd0, 32'd0, 1'b1);

        if (eod)
            rearm_scanner();
        else if (closed)
            scan_phase = SCAN_DRAIN;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: offers queued bytes, predicting each accepted one
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        head_byte_t next_byte;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            byte_value  <= 8'h00;
            end_of_data <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_fields(byte_value, end_of_data);
                bytes_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    next_byte    = pending_bytes.pop_front();
                    in_valid    <= 1'b1;
                    byte_value  <= next_byte.value;
                    end_of_data <= next_byte.last;
                    send_wait    = pick_gap(bytes_taken);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: checks each result transaction and paces out_ready
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (field_queue.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: kind %0d offset %0d length %0d final %0b",
                                 field_kind, field_offset, field_length, final_result);
                end
                else
                begin
                    want = field_queue.pop_front();
                    if (field_kind !== want.kind || field_offset !== want.offset ||
                        field_length !== want.length || final_result !== want.closes_head)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch at result %0d: ", fields_seen,
                                     "expected kind %0d offset %0d ", want.kind, want.offset,
                                     "length %0d final %0b, ", want.length, want.closes_head,
                                     "got kind %0d offset %0d ", field_kind, field_offset,
                                     "length %0d final %0b", field_length, final_result);
                    end
                end
                fields_seen++;
                recv_wait = pick_gap(fields_seen);
            end
            else if (!out_ready && recv_wait > 0)
                recv_wait--;
            out_ready <= !hold_off && recv_wait == 0;
        end
    end

    // Long receiver stall while the sender keeps going, so the result queue
    // fills and the input is held back.
    initial
    begin
        wait (bytes_taken >= 250);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Head construction
    // ------------------------------------------------------------------
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            head_buf.push_back(s[i]);
    endtask

    // Random token; printable bytes only, or any byte except a space.
    task automatic add_token(input int n, input bit any_value);
        logic [7:0] c;
        for (int i = 0; i < n; i++)
        begin
            if (any_value)
            begin
                c = 8'($urandom_range(0, 255));
                if (c == CHAR_SPACE)
                    c = 8'hFF;
            end
            else
                c = 8'($urandom_range(33, 126));
            head_buf.push_back(c);
        end
    endtask

    task automatic add_crlf();
        head_buf.push_back(CHAR_CR);
        head_buf.push_back(CHAR_LF);
    endtask

    // Moves the assembled head into the send queue, marking its last byte.
    task automatic flush_head();
        head_byte_t hb;
        int n;
        n = head_buf.size();
        for (int i = 0; i < n; i++)
        begin
            hb.value = head_buf[i];
            hb.last  = (i == n - 1);
            pending_bytes.push_back(hb);
        end
        head_buf.delete();
    endtask

    // A well formed head with random content, sometimes cut short.
    task automatic build_head();
        int cut;
        add_token($urandom_range(0, 8), 1'b0);
        head_buf.push_back(CHAR_SPACE);
        add_token($urandom_range(0, 20), 1'b1);
        head_buf.push_back(CHAR_SPACE);
        if ($urandom_range(0, 1))
            add_text("HTTP/1.1");
        else
            add_token($urandom_range(0, 10), 1'b0);
        // A doubled CR keeps the first CR inside the field.
        if ($urandom_range(0, 7) == 0)
            head_buf.push_back(CHAR_CR);
        add_crlf();
        repeat ($urandom_range(0, 3))
        begin
            add_token($urandom_range(1, 8), 1'b0);
            add_text(": ");
            add_token($urandom_range(0, 12), 1'b0);
            add_crlf();
        end
        // Partial keyword matches in front of the real one.
        case ($urandom_range(0, 5))
            0: add_text("H");
            1: add_text("Hos");
            2: add_text("HoHo");
            default:
            begin
            end
        endcase
        add_text("Host");
        if ($urandom_range(0, 5) == 0)
            add_token(2, 1'b1);
        else
            add_text(": ");
        add_token($urandom_range(0, 16), 1'b0);
        if ($urandom_range(0, 7) == 0)
            head_buf.push_back(CHAR_CR);
        add_crlf();
        // Either end on the host line or carry on with bytes to be dropped.
        if ($urandom_range(0, 2) != 0)
        begin
            repeat ($urandom_range(0, 2))
            begin
                add_token($urandom_range(1, 6), 1'b0);
                add_text(": x");
                add_crlf();
            end
            add_crlf();
        end
        if ($urandom_range(0, 4) == 0)
        begin
            cut = $urandom_range(1, head_buf.size());
            while (head_buf.size() > cut)
                void'(head_buf.pop_back());
        end
        flush_head();
    endtask

    // Random bytes, biased towards delimiters and the keyword's first byte.
    task automatic build_noise();
        repeat ($urandom_range(1, 30))
        begin
            case ($urandom_range(0, 7))
                0: head_buf.push_back(CHAR_SPACE);
                1: head_buf.push_back(CHAR_CR);
                2: head_buf.push_back(CHAR_LF);
                3: head_buf.push_back(CHAR_H);
                default: head_buf.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        flush_head();
    endtask

    // ------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------
    initial
    begin
        int short_items;

        // Empty method, one byte URL, empty version and empty host value,
        // with the end of data on the host's closing byte.
        head_buf.push_back(CHAR_SPACE);
        head_buf.push_back(8'hFF);
        head_buf.push_back(CHAR_SPACE);
        add_crlf();
        add_text("Host");
        head_buf.push_back(8'h00);
        head_buf.push_back(8'h00);
        add_crlf();
        flush_head();
        // A single zero byte that ends the data.
        head_buf.push_back(8'h00);
        flush_head();
        // Doubled CR in the version, and the data ends on its closing byte.
        add_text("A B C");
        head_buf.push_back(CHAR_CR);
        add_crlf();
        flush_head();

        // Random heads and noise until the byte budget is used.
        short_items = 0;
        while (short_items < SHORT_ITEMS)
        begin
            total_bytes = pending_bytes.size();
            if ($urandom_range(0, 5) == 0)
                build_noise();
            else
                build_head();
            short_items += pending_bytes.size() - total_bytes;
        end
        total_bytes = pending_bytes.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_taken != total_bytes)
            @(negedge clk);
        while (field_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && field_queue.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* http_request_head_field_locator.f */
hw/rtl/hrfl_pkg.sv
hw/rtl/hrfl_parser.sv
hw/rtl/hrfl_result_queue.sv
hw/rtl/http_request_head_field_locator.sv
dv/http_request_head_field_locator_tb.sv
